[hdl/twlc_pkg.sv]
// Package for the two-way LRU data cache: field positions, widths, default sizes
// and the command and status bundles between the controller and the datapath.
// No dependencies.
package twlc_pkg;

    // Instruction word fields.
    localparam int INSTR_W      = 32;
    localparam int OPCODE_W     = 6;
    localparam int OPCODE_LSB   = 26;
    localparam int REG_FIELD_W  = 3;
    localparam int REG_LSB      = 16;
    localparam int ADDR_W       = 14;
    localparam int ADDR_LSB     = 2;
    localparam int DATA_W       = 32;

    localparam logic [OPCODE_W-1:0] LOAD_OPCODE     = 6'b100011;
    localparam logic [DATA_W-1:0]   MEM_INIT_OFFSET = 32'd5;

    // A cache line keeps the full word address as its tag, then the data word.
    localparam int LINE_W = ADDR_W + DATA_W;

    // Stream widths.
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 40;

    // Default sizes.
    localparam int DEF_NUM_SETS  = 8;
    localparam int DEF_MEM_WORDS = 128;
    localparam int DEF_NUM_REGS  = 8;

    typedef struct packed {
        logic init_step;   // write one word of the memory init sweep
        logic accept;      // capture an incoming item
        logic commit;      // update state and load the output register
    } twlc_cmd_t;

    typedef struct packed {
        logic init_last;   // the sweep is at its last word
        logic out_busy;    // the output register holds an item that is not taken this cycle
    } twlc_status_t;

endpackage

[hdl/two_way_lru_data_cache.sv]
// Top level of the two-way LRU data cache: stream ports, controller and datapath.
// Depends on twlc_pkg, twlc_ctrl, twlc_dpath (and through it twlc_ram).
//
// Each input item is one 32-bit load or store instruction word. Opcode 100011 is
// a load and every other opcode a store; the register index comes from bits
// 18:16 (wrapped modulo NUM_REGS) and the word address from bits 15:2. The
// address selects one of NUM_SETS sets of a two-way cache with one LRU bit per
// set. A load hit returns the cached word, a load miss fills a way (an invalid
// way first, otherwise the least recently used one) from main memory, and either
// way writes the register. A store hit updates only the cache line and its LRU
// bit; a store miss writes main memory without allocating. Evicted lines are
// dropped, not written back. An address at or above MEM_WORDS is flagged and
// changes no state. Every item produces exactly one result item. After reset
// the block writes the initial contents (entry i holds i plus 5) into every
// main memory word, with s_tready low. After that each item goes through the
// accept step, the registered read of the tag, data, LRU and memory arrays,
// and the update step that compares tags, writes the arrays and loads the
// output register. The next item is accepted in the cycle after that, even
// while the result still waits on m_tready; its update step then waits until
// the output register is free.
module two_way_lru_data_cache
    import twlc_pkg::*;
#(
    parameter int NUM_SETS  = DEF_NUM_SETS,
    parameter int MEM_WORDS = DEF_MEM_WORDS,
    parameter int NUM_REGS  = DEF_NUM_REGS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [31:0] instruction
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [0] hit, [3:1] dest_register, [35:4] load_value, [36] address_error, [39:37] zero
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tuser    // [0] is_load
);

    twlc_cmd_t    cmd;
    twlc_status_t status;

    twlc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    twlc_dpath #(
        .NUM_SETS  (NUM_SETS),
        .MEM_WORDS (MEM_WORDS),
        .NUM_REGS  (NUM_REGS)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

[hdl/twlc_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module twlc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[hdl/twlc_ctrl.sv]
// Controller of the two-way LRU data cache: sequences the memory init sweep and
// the accept, read and update steps of each item. Uses twlc_pkg.
module twlc_ctrl
    import twlc_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  twlc_status_t status,
    output twlc_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_INIT = 4'b0001,
        ST_IDLE = 4'b0010,
        ST_READ = 4'b0100,
        ST_LOOK = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_INIT: begin
                cmd.init_step = 1'b1;
                if (status.init_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_LOOK;
            end
            ST_LOOK: begin
                // Hold the lookup until the output register can take the result.
                if (!status.out_busy) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[hdl/twlc_dpath.sv]
// Datapath of the two-way LRU data cache: instruction decode, set index, cache
// ways, LRU bits, main memory, register file and output register.
// Uses twlc_pkg and twlc_ram.
module twlc_dpath
    import twlc_pkg::*;
#(
    parameter int NUM_SETS  = DEF_NUM_SETS,
    parameter int MEM_WORDS = DEF_MEM_WORDS,
    parameter int NUM_REGS  = DEF_NUM_REGS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  twlc_cmd_t             cmd,
    output twlc_status_t          status,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic                  m_tuser
);

    localparam int SET_W     = $clog2(NUM_SETS);
    localparam int RF_AW     = $clog2(NUM_REGS);
    localparam int MEM_AW    = $clog2(MEM_WORDS);
    // Quotient by NUM_SETS through a reciprocal that is exact for every ADDR_W-bit value.
    localparam int DIV_SHIFT = ADDR_W + SET_W;
    localparam int RECIP_W   = ADDR_W + 2;
    localparam int PROD_W    = ADDR_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(NUM_SETS) - 64'd1) / 64'(NUM_SETS));
    localparam logic [SET_W-1:0] SETS_LOW = SET_W'(NUM_SETS);
    localparam int RCNT_W = 6;

    // Captured item and the low bits of its quotient.
    logic [INSTR_W-1:0] instr_reg, instr_next;
    logic [SET_W-1:0]   q_reg, q_next;
    logic [PROD_W-1:0]  q_prod;

    logic [MEM_AW-1:0]  init_cnt_reg, init_cnt_next;

    logic [NUM_SETS-1:0] valid0_reg, valid0_next;
    logic [NUM_SETS-1:0] valid1_reg, valid1_next;
    logic [DATA_W-1:0]   rf_reg [NUM_REGS];

    logic                out_valid_reg, out_valid_next;
    logic                out_hit_reg, out_load_reg, out_err_reg;
    logic [REG_FIELD_W-1:0] out_dest_reg;
    logic [DATA_W-1:0]   out_value_reg;

    // Decode.
    logic [ADDR_W-1:0]      addr;
    logic [REG_FIELD_W-1:0] regf;
    logic                   is_load;
    logic [SET_W-1:0]       set_idx;
    logic [RF_AW-1:0]       ridx;
    logic [RCNT_W-1:0]      rwrap;
    logic                   addr_err;
    logic [MEM_AW-1:0]      mem_addr;

    // Array read data.
    logic [LINE_W-1:0] line0, line1;
    logic [DATA_W-1:0] mem_rd;
    logic              lru_rd;

    // Lookup.
    logic              v0, v1, hit0, hit1, hit, fill_way, touch_way;
    logic [DATA_W-1:0] rf_rd, load_val;

    // Array writes.
    logic              way0_we, way1_we, lru_we, mem_we, rf_we;
    logic [LINE_W-1:0] line_wdata;
    logic [MEM_AW-1:0] mem_waddr;
    logic [DATA_W-1:0] mem_wdata;

    assign q_prod = PROD_W'(s_tdata[ADDR_LSB +: ADDR_W]) * PROD_W'(RECIP);

    assign addr     = instr_reg[ADDR_LSB +: ADDR_W];
    assign regf     = instr_reg[REG_LSB +: REG_FIELD_W];
    assign is_load  = (instr_reg[OPCODE_LSB +: OPCODE_W] == LOAD_OPCODE);
    // Remainder = addr - q * NUM_SETS; only the low SET_W bits matter.
    assign set_idx  = addr[SET_W-1:0] - SET_W'(q_reg * SETS_LOW);
    assign addr_err = (32'(addr) >= 32'(MEM_WORDS));
    assign mem_addr = MEM_AW'(32'(addr));

    // Register index wraps modulo NUM_REGS.
    always_comb begin
        rwrap = RCNT_W'(regf);
        for (int k = 0; k < REG_FIELD_W; k++) begin
            if (rwrap >= RCNT_W'(NUM_REGS)) begin
                rwrap = rwrap - RCNT_W'(NUM_REGS);
            end
        end
        ridx = rwrap[RF_AW-1:0];
    end

    assign rf_rd = rf_reg[ridx];

    assign v0   = valid0_reg[set_idx];
    assign v1   = valid1_reg[set_idx];
    assign hit0 = v0 && (line0[LINE_W-1:DATA_W] == addr);
    assign hit1 = !hit0 && v1 && (line1[LINE_W-1:DATA_W] == addr);
    assign hit  = hit0 || hit1;

    // Fill goes to an invalid way first, then to the victim named by the LRU bit.
    always_comb begin
        priority if (!v0) begin
            fill_way = 1'b0;
        end else if (!v1) begin
            fill_way = 1'b1;
        end else begin
            fill_way = lru_rd;
        end
    end

    assign load_val  = hit ? (hit1 ? line1[DATA_W-1:0] : line0[DATA_W-1:0]) : mem_rd;
    assign touch_way = (is_load && !hit) ? fill_way : hit1;

    always_comb begin
        way0_we    = 1'b0;
        way1_we    = 1'b0;
        lru_we     = 1'b0;
        mem_we     = 1'b0;
        rf_we      = 1'b0;
        line_wdata = {addr, (is_load ? load_val : rf_rd)};
        mem_waddr  = mem_addr;
        mem_wdata  = rf_rd;
        if (cmd.init_step) begin
            mem_we    = 1'b1;
            mem_waddr = init_cnt_reg;
            mem_wdata = DATA_W'(init_cnt_reg) + MEM_INIT_OFFSET;
        end else if (cmd.commit && !addr_err) begin
            if (is_load) begin
                rf_we  = 1'b1;
                lru_we = 1'b1;
                if (!hit) begin
                    way0_we = !fill_way;
                    way1_we = fill_way;
                end
            end else if (hit) begin
                lru_we  = 1'b1;
                way0_we = hit0;
                way1_we = hit1;
            end else begin
                mem_we = 1'b1;
            end
        end
    end

    twlc_ram #(.WIDTH(LINE_W), .DEPTH(NUM_SETS)) u_way0 (
        .aclk    (aclk),
        .wr_en   (way0_we),
        .wr_addr (set_idx),
        .wr_data (line_wdata),
        .rd_addr (set_idx),
        .rd_data (line0)
    );

    twlc_ram #(.WIDTH(LINE_W), .DEPTH(NUM_SETS)) u_way1 (
        .aclk    (aclk),
        .wr_en   (way1_we),
        .wr_addr (set_idx),
        .wr_data (line_wdata),
        .rd_addr (set_idx),
        .rd_data (line1)
    );

    // A set bit means way 0 was used last.
    twlc_ram #(.WIDTH(1), .DEPTH(NUM_SETS)) u_lru (
        .aclk    (aclk),
        .wr_en   (lru_we),
        .wr_addr (set_idx),
        .wr_data (!touch_way),
        .rd_addr (set_idx),
        .rd_data (lru_rd)
    );

    twlc_ram #(.WIDTH(DATA_W), .DEPTH(MEM_WORDS)) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_addr),
        .rd_data (mem_rd)
    );

    always_comb begin
        instr_next    = instr_reg;
        q_next        = q_reg;
        init_cnt_next = init_cnt_reg;
        valid0_next   = valid0_reg;
        valid1_next   = valid1_reg;
        if (cmd.accept) begin
            instr_next = s_tdata;
            q_next     = SET_W'(q_prod >> DIV_SHIFT);
        end
        if (cmd.init_step) begin
            init_cnt_next = init_cnt_reg + MEM_AW'(1);
        end
        if (way0_we) begin
            valid0_next[set_idx] = 1'b1;
        end
        if (way1_we) begin
            valid1_next[set_idx] = 1'b1;
        end
        out_valid_next = out_valid_reg && !m_tready;
        if (cmd.commit) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_cnt_reg  <= '0;
            valid0_reg    <= '0;
            valid1_reg    <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_REGS; i++) begin
                rf_reg[i] <= '0;
            end
        end else begin
            init_cnt_reg  <= init_cnt_next;
            valid0_reg    <= valid0_next;
            valid1_reg    <= valid1_next;
            out_valid_reg <= out_valid_next;
            if (rf_we) begin
                rf_reg[ridx] <= load_val;
            end
        end
    end

    always_ff @(posedge aclk) begin
        instr_reg <= instr_next;
        q_reg     <= q_next;
        if (cmd.commit) begin
            out_hit_reg   <= hit && !addr_err;
            out_load_reg  <= is_load;
            out_dest_reg  <= regf;
            out_value_reg <= (is_load && !addr_err) ? load_val : '0;
            out_err_reg   <= addr_err;
        end
    end

    assign status.init_last = (init_cnt_reg == MEM_AW'(MEM_WORDS - 1));
    assign status.out_busy  = out_valid_reg && !m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_load_reg;
    assign m_tdata  = {3'b000, out_err_reg, out_value_reg, out_dest_reg, out_hit_reg};

endmodule

[hdl/twlc_checker.sv]
// Port-level checker for the two-way LRU data cache, bound to the top level.
// Uses twlc_pkg.
module twlc_checker
    import twlc_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tuser
);

    // Reset starts the memory init sweep with both channels quiet.
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !s_tready && !m_tvalid)
        else $error("channels active right after reset");

    // Only one item is in work at a time.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item accepted while one is in work");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Stores and address errors return no load value and no hit on error.
    a_value_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[36] || !m_tuser) |->
            m_tdata[35:4] == '0 && !(m_tdata[36] && m_tdata[0]))
        else $error("load value or hit set on a store or address error");

endmodule

bind two_way_lru_data_cache twlc_checker u_checker (.*);
